// ===== hdl/ksq_pkg.sv =====
// shared types and constants of the keyframe slew sequencer
package ksq_pkg;

  localparam int ANGLE_W     = 16;
  localparam int SLEW_W      = 8;
  localparam int FCNT_W      = 7;
  localparam int FRAME_IDX_W = 6;
  localparam int SERVO_IDX_W = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_START = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

  localparam logic [SLEW_W-1:0] SLEW_RESET = 8'd3;
  localparam logic [FCNT_W-1:0] FCNT_RESET = 7'd2;

endpackage

// ===== hdl/ksq_ram.sv =====
// generic single write port ram with registered read
module ksq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ksq_slew.sv =====
// slew limiter: moves a goal by one step toward its target, or holds it when it is closer than one step
module ksq_slew import ksq_pkg::*; (
  input  logic signed [ANGLE_W-1:0] goal,
  input  logic signed [ANGLE_W-1:0] target,
  input  logic        [SLEW_W-1:0]  slew_step,
  output logic signed [ANGLE_W-1:0] goal_next
);

  localparam int EW = ANGLE_W + 2;

  logic signed [EW-1:0] g_ext;
  logic signed [EW-1:0] t_ext;
  logic signed [EW-1:0] sp_ext;
  logic signed [EW-1:0] t_lo;
  logic signed [EW-1:0] t_hi;
  logic signed [EW-1:0] sum;

  always_comb begin
    g_ext  = EW'(goal);
    t_ext  = EW'(target);
    sp_ext = $signed({{(EW - SLEW_W){1'b0}}, slew_step});
    t_lo   = t_ext - sp_ext;
    t_hi   = t_ext + sp_ext;
    priority if (g_ext <= t_lo) begin
      sum = g_ext + sp_ext;
    end else if (g_ext >= t_hi) begin
      sum = g_ext - sp_ext;
    end else begin
      sum = g_ext;
    end
    // a goal only moves toward a target that far away, so this stays in range
    goal_next = sum[ANGLE_W-1:0];
  end

endmodule

// ===== hdl/servo_keyframe_slew_sequencer_core.sv =====
// top level: keyframe store, goal registers and the per-servo run sequencer
//
// Load and start items are taken without raising busy; configuration writes are always
// taken (cfg_ready is tied high) and belong to idle time. A run item while the sequence is
// active walks the servos through the single keyframe memory read port and the shared slew
// unit: an issue state, then one step per servo, with a second read for keyframe 1 ahead of
// each servo's step on the first run after start. busy is high from the issue state through
// the last servo's step. Results come out servo 0 first, each on out_valid for exactly one
// cycle; the receiver cannot stall them. On a normal run they come one per cycle; on the
// first run after start the second read lies between one result and the next.
// A run while idle produces nothing. The keyframe memory is not cleared at reset: read only
// frames that were loaded.
module servo_keyframe_slew_sequencer_core import ksq_pkg::*; #(
  parameter int SERVOS     = 12,
  parameter int MAX_FRAMES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [FRAME_IDX_W-1:0]        in_frame_index,
  input  logic [SERVO_IDX_W-1:0]        in_servo_index,
  input  logic signed [ANGLE_W-1:0]     in_angle,
  input  logic                          in_step_tick,
  output logic                          out_valid,
  output logic [SERVO_IDX_W-1:0]        out_servo_id,
  output logic signed [ANGLE_W-1:0]     out_goal_angle,
  output logic                          out_done_res,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int DEPTH = MAX_FRAMES * SERVOS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(MAX_FRAMES);
  localparam int SW    = (SERVOS > 1) ? $clog2(SERVOS) : 1;
  localparam int CW    = (FW + 1 > FCNT_W) ? FW + 1 : FCNT_W;
  localparam int MFW   = $clog2(MAX_FRAMES + 1);
  localparam int LFW   = (MFW > FRAME_IDX_W) ? MFW : FRAME_IDX_W;
  localparam int MSW   = $clog2(SERVOS + 1);
  localparam int LSW   = (MSW > SERVO_IDX_W) ? MSW : SERVO_IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_TGT,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;

  logic        [SLEW_W-1:0]  slew_r;
  logic        [FCNT_W-1:0]  fcnt_r;
  logic        [FW-1:0]      step_r;
  logic        [SW-1:0]      cnt_r;
  logic                      first_r;
  logic                      active_r;
  logic                      tick_r;
  logic                      done_r;
  logic signed [ANGLE_W-1:0] base_r;
  logic signed [ANGLE_W-1:0] goals_r [SERVOS];

  logic                      out_valid_r;
  logic [SERVO_IDX_W-1:0]    out_servo_id_r;
  logic signed [ANGLE_W-1:0] out_goal_r;
  logic                      out_done_r;
  logic                      out_last_r;

  logic                      in_accept;
  logic                      run_go;
  logic                      load_ok;
  logic [AW-1:0]             wr_addr;
  logic                      rd_en;
  logic [FW-1:0]             rd_frame;
  logic [SW-1:0]             rd_servo;
  logic [AW-1:0]             rd_addr;
  logic [ANGLE_W-1:0]        rd_data;
  logic                      cnt_last;
  logic [CW-1:0]             fc_ext;
  logic [CW-1:0]             fc_clamp;
  logic                      ends_run;
  logic signed [ANGLE_W-1:0] cur_goal;
  logic signed [ANGLE_W-1:0] slew_goal;
  logic signed [ANGLE_W-1:0] new_goal;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;
  assign run_go    = in_accept && (in_cmd == CMD_RUN) && active_r;
  assign cnt_last  = (cnt_r == SW'(SERVOS - 1));

  // out-of-range loads are dropped
  assign load_ok = in_accept && (in_cmd == CMD_LOAD)
                && (LFW'(in_frame_index) < LFW'(MAX_FRAMES))
                && (LSW'(in_servo_index) < LSW'(SERVOS));
  assign wr_addr = AW'(AW'(in_frame_index) * AW'(SERVOS)) + AW'(in_servo_index);

  // a tick ends the sequence unless there is a further keyframe
  assign fc_ext   = CW'(fcnt_r);
  assign fc_clamp = (fc_ext > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : fc_ext;
  assign ends_run = !((fc_clamp >= CW'(2)) && (CW'(step_r) < fc_clamp - CW'(1)));

  always_comb begin
    rd_en     = 1'b0;
    rd_frame  = step_r;
    rd_servo  = cnt_r;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (run_go) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        rd_en     = 1'b1;
        rd_frame  = first_r ? FW'(1) : step_r;
        state_nxt = first_r ? S_TGT : S_EXEC;
      end
      S_TGT: begin
        rd_en     = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // fetch for the next servo overlaps this one
        rd_en    = !cnt_last;
        rd_frame = first_r ? FW'(1) : step_r;
        rd_servo = SW'(cnt_r + 1'b1);
        if (cnt_last) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = first_r ? S_TGT : S_EXEC;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign rd_addr = AW'(AW'(rd_frame) * AW'(SERVOS)) + AW'(rd_servo);

  ksq_ram #(
    .WIDTH (ANGLE_W),
    .DEPTH (DEPTH)
  ) u_kf_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (wr_addr),
    .wdata (in_angle),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign cur_goal = first_r ? base_r : goals_r[cnt_r];

  ksq_slew u_slew (
    .goal      (cur_goal),
    .target    ($signed(rd_data)),
    .slew_step (slew_r),
    .goal_next (slew_goal)
  );

  // on a tick the goal takes the current step's keyframe either way
  assign new_goal = tick_r ? $signed(rd_data) : slew_goal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slew_r      <= SLEW_RESET;
      fcnt_r      <= FCNT_RESET;
      step_r      <= FW'(1);
      cnt_r       <= '0;
      first_r     <= 1'b0;
      active_r    <= 1'b0;
      tick_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SERVOS; i++) begin
        goals_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SLEW_STEP) begin
          slew_r <= cfg_wdata[SLEW_W-1:0];
        end else if (cfg_index == CFG_FRAME_COUNT) begin
          fcnt_r <= cfg_wdata[FCNT_W-1:0];
        end
      end

      if (in_accept && (in_cmd == CMD_START)) begin
        step_r   <= FW'(1);
        first_r  <= 1'b1;
        active_r <= 1'b1;
      end

      if (run_go) begin
        cnt_r  <= '0;
        tick_r <= in_step_tick;
        done_r <= in_step_tick && ends_run;
      end

      if (state_r == S_TGT) begin
        base_r <= $signed(rd_data);
      end

      if (state_r == S_EXEC) begin
        goals_r[cnt_r] <= new_goal;
        out_valid_r    <= 1'b1;
        out_servo_id_r <= SERVO_IDX_W'(cnt_r);
        out_goal_r     <= new_goal;
        out_done_r     <= done_r;
        out_last_r     <= cnt_last;
        if (cnt_last) begin
          first_r <= 1'b0;
          if (done_r) begin
            active_r <= 1'b0;
          end else if (tick_r) begin
            step_r <= FW'(step_r + 1'b1);
          end
        end else begin
          cnt_r <= SW'(cnt_r + 1'b1);
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_servo_id   = out_servo_id_r;
  assign out_goal_angle = out_goal_r;
  assign out_done_res   = out_done_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_valid_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_valid_r |-> $past(state_r == S_EXEC))
    else $error("result strobe without a servo step");

  a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> (state_r == S_IDLE) && !first_r)
    else $error("run not closed on its final result");

  a_idle_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(active_r) |-> out_valid_r && out_done_r && out_last_r)
    else $error("sequence went idle without a done run");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (cnt_r <= SW'(SERVOS - 1)))
    else $error("servo counter out of range");
`endif

endmodule
